// ----- hdl/wwbc_pkg.sv -----
// ----------------------------------------------------------------------------
// wwbc_pkg
// Shared constants, operation codes, sequencer states and the memory control
// bundle for the window write-back cache.
// ----------------------------------------------------------------------------
package wwbc_pkg;

  localparam int WINDOW_BYTES = 128;
  localparam int TOP_ADDRESS  = 65535;

  localparam int BUF_DEPTH  = WINDOW_BYTES + 1;
  localparam int BACK_DEPTH = TOP_ADDRESS + 2;
  localparam int BUF_AW     = $clog2(BUF_DEPTH);
  localparam int RAM_AW     = $clog2(BACK_DEPTH);
  localparam int CNT_W      = $clog2(BUF_DEPTH + 1);

  localparam logic [15:0] BASE_NONE = 16'(TOP_ADDRESS);
  localparam logic [15:0] BASE_CLAMP =
      (TOP_ADDRESS + 1 >= WINDOW_BYTES) ? 16'(TOP_ADDRESS + 1 - WINDOW_BYTES) : 16'd0;

  localparam logic [2:0] OP_RD_BYTE = 3'd0;
  localparam logic [2:0] OP_WR_BYTE = 3'd1;
  localparam logic [2:0] OP_RD_WORD = 3'd2;
  localparam logic [2:0] OP_WR_WORD = 3'd3;
  localparam logic [2:0] OP_FLUSH   = 3'd4;
  localparam logic [2:0] OP_FLUSH_IN = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WB,
    ST_FILL,
    ST_ACC_A,
    ST_ACC_B,
    ST_ACC_C,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              buf_we;
    logic [BUF_AW-1:0] buf_waddr;
    logic [7:0]        buf_wdata;
    logic [BUF_AW-1:0] buf_raddr;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [RAM_AW-1:0] ram_raddr;
  } mem_ctrl_t;

endpackage

// ----- hdl/wwbc_mem.sv -----
// ----------------------------------------------------------------------------
// wwbc_mem
// Window buffer and backing RAM, each one write and one registered read port.
// ----------------------------------------------------------------------------
module wwbc_mem (
  input  logic                clk_i,
  input  wwbc_pkg::mem_ctrl_t ctrl_i,
  output logic [7:0]          buf_rdata_o,
  output logic [7:0]          ram_rdata_o
);

  logic [7:0] buf_mem_q [wwbc_pkg::BUF_DEPTH];
  logic [7:0] ram_mem_q [wwbc_pkg::BACK_DEPTH];
  logic [7:0] buf_rdata_q;
  logic [7:0] ram_rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.buf_we) begin
      buf_mem_q[ctrl_i.buf_waddr] <= ctrl_i.buf_wdata;
    end
    buf_rdata_q <= buf_mem_q[ctrl_i.buf_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ram_we) begin
      ram_mem_q[ctrl_i.ram_waddr] <= ctrl_i.ram_wdata;
    end
    if (ctrl_i.ram_re) begin
      ram_rdata_q <= ram_mem_q[ctrl_i.ram_raddr];
    end
  end

  assign buf_rdata_o = buf_rdata_q;
  assign ram_rdata_o = ram_rdata_q;

endmodule

// ----- hdl/window_write_back_cache_top.sv -----
// ----------------------------------------------------------------------------
// window_write_back_cache_top
// Single-window write-back cache in front of a byte-wide backing RAM.
// ----------------------------------------------------------------------------
// One transfer is worked on at a time. A hit passes from CHECK through ACC_A,
// then ACC_B for a word and ACC_C for a read, to DONE. A flush that writes
// nothing back, or an ignored op, goes from CHECK straight to DONE. The next
// input transfer can be taken once DONE has passed the result to the output
// register. A miss adds one pass to refill the window. It adds a second pass
// of the same length first when the old window is dirty. A flush of a dirty
// window takes one such pass (OP_FLUSH_IN only when the address lies in the
// window). These passes move one byte a cycle through the window buffer and
// backing RAM, addressed through one shared base-plus-count adder. A new
// input transfer is taken while a finished result still waits in the output
// register. The backing RAM has no reset and needs no clearing.
module window_write_back_cache_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [15:0] address_i,
  input  logic [15:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] read_data_o,
  output logic        hit_o,
  output logic        wrote_back_o,
  output logic [15:0] window_start_o,
  output logic        window_valid_o
);

  localparam int RAM_AW = wwbc_pkg::RAM_AW;
  localparam int BUF_AW = wwbc_pkg::BUF_AW;
  localparam int CNT_W  = wwbc_pkg::CNT_W;

  wwbc_pkg::state_e    state_q, state_d;
  wwbc_pkg::mem_ctrl_t mem_ctrl;

  logic [2:0]        op_q, op_d;
  logic [15:0]       addr_q, addr_d;
  logic [15:0]       data_q, data_d;
  logic [15:0]       base_q, base_d;
  logic              held_q, held_d;
  logic              dirty_q, dirty_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              hit_q, hit_d;
  logic              wb_q, wb_d;
  logic [15:0]       rd_q, rd_d;
  logic [RAM_AW-1:0] sum_prev_q;
  logic              inr_prev_q;
  logic              out_valid_q, out_valid_d;
  logic [15:0]       out_rd_q, out_rd_d;
  logic              out_hit_q, out_hit_d;
  logic              out_wb_q, out_wb_d;
  logic [15:0]       out_start_q, out_start_d;
  logic              out_held_q, out_held_d;

  logic [7:0]        buf_rdata;
  logic [7:0]        ram_rdata;
  logic              in_xfer;
  logic              out_free;
  logic              op_ok;
  logic              is_access;
  logic              is_read;
  logic              is_word;
  logic              is_flush;
  logic              in_win;
  logic [16:0]       win_last;
  logic [15:0]       new_base;
  logic [RAM_AW-1:0] sum;
  logic              inr;
  logic              cnt_end;
  logic [15:0]       off_full;
  logic [BUF_AW-1:0] off;
  logic [BUF_AW-1:0] off1;

  assign in_stall_o = (state_q != wwbc_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign op_ok     = ((op_q == wwbc_pkg::OP_RD_BYTE) || (op_q == wwbc_pkg::OP_WR_BYTE) ||
                      (op_q == wwbc_pkg::OP_RD_WORD) || (op_q == wwbc_pkg::OP_WR_WORD) ||
                      (op_q == wwbc_pkg::OP_FLUSH) || (op_q == wwbc_pkg::OP_FLUSH_IN)) &&
                     ({1'b0, addr_q} <= 17'(wwbc_pkg::TOP_ADDRESS));
  assign is_access = (op_q == wwbc_pkg::OP_RD_BYTE) || (op_q == wwbc_pkg::OP_WR_BYTE) ||
                     (op_q == wwbc_pkg::OP_RD_WORD) || (op_q == wwbc_pkg::OP_WR_WORD);
  assign is_read   = (op_q == wwbc_pkg::OP_RD_BYTE) || (op_q == wwbc_pkg::OP_RD_WORD);
  assign is_word   = (op_q == wwbc_pkg::OP_RD_WORD) || (op_q == wwbc_pkg::OP_WR_WORD);
  assign is_flush  = (op_q == wwbc_pkg::OP_FLUSH) || (op_q == wwbc_pkg::OP_FLUSH_IN);

  assign win_last = {1'b0, base_q} + 17'(wwbc_pkg::WINDOW_BYTES - 1);
  assign in_win   = held_q && (addr_q >= base_q) && ({1'b0, addr_q} <= win_last);
  assign new_base = (({1'b0, addr_q} + 17'(wwbc_pkg::WINDOW_BYTES)) >
                     17'(wwbc_pkg::TOP_ADDRESS)) ? wwbc_pkg::BASE_CLAMP : addr_q;

  // shared address adder for write-back and refill passes
  assign sum     = RAM_AW'(base_q) + RAM_AW'(cnt_q);
  assign inr     = (sum < RAM_AW'(wwbc_pkg::BACK_DEPTH));
  assign cnt_end = (cnt_q == CNT_W'(wwbc_pkg::BUF_DEPTH));

  assign off_full = addr_q - base_q;
  assign off      = off_full[BUF_AW-1:0];
  assign off1     = off + BUF_AW'(1);

  wwbc_mem u_mem (
    .clk_i       (clk_i),
    .ctrl_i      (mem_ctrl),
    .buf_rdata_o (buf_rdata),
    .ram_rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      wwbc_pkg::ST_IDLE: begin
        if (in_xfer) state_d = wwbc_pkg::ST_CHECK;
      end
      wwbc_pkg::ST_CHECK: begin
        if (!op_ok) begin
          state_d = wwbc_pkg::ST_DONE;
        end else if (is_access) begin
          if (in_win)       state_d = wwbc_pkg::ST_ACC_A;
          else if (dirty_q) state_d = wwbc_pkg::ST_WB;
          else              state_d = wwbc_pkg::ST_FILL;
        end else if (((op_q == wwbc_pkg::OP_FLUSH) || in_win) && dirty_q) begin
          state_d = wwbc_pkg::ST_WB;
        end else begin
          state_d = wwbc_pkg::ST_DONE;
        end
      end
      wwbc_pkg::ST_WB: begin
        if (cnt_end) state_d = is_flush ? wwbc_pkg::ST_DONE : wwbc_pkg::ST_FILL;
      end
      wwbc_pkg::ST_FILL: begin
        if (cnt_end) state_d = wwbc_pkg::ST_ACC_A;
      end
      wwbc_pkg::ST_ACC_A: begin
        if (is_word)      state_d = wwbc_pkg::ST_ACC_B;
        else if (is_read) state_d = wwbc_pkg::ST_ACC_C;
        else              state_d = wwbc_pkg::ST_DONE;
      end
      wwbc_pkg::ST_ACC_B: begin
        state_d = is_read ? wwbc_pkg::ST_ACC_C : wwbc_pkg::ST_DONE;
      end
      wwbc_pkg::ST_ACC_C: begin
        state_d = wwbc_pkg::ST_DONE;
      end
      wwbc_pkg::ST_DONE: begin
        if (out_free) state_d = wwbc_pkg::ST_IDLE;
      end
      default: state_d = wwbc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mem_ctrl    = '0;
    op_d        = op_q;
    addr_d      = addr_q;
    data_d      = data_q;
    base_d      = base_q;
    held_d      = held_q;
    dirty_d     = dirty_q;
    cnt_d       = cnt_q;
    hit_d       = hit_q;
    wb_d        = wb_q;
    rd_d        = rd_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_rd_d    = out_rd_q;
    out_hit_d   = out_hit_q;
    out_wb_d    = out_wb_q;
    out_start_d = out_start_q;
    out_held_d  = out_held_q;
    case (state_q)
      wwbc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          op_d   = op_i;
          addr_d = address_i;
          data_d = write_data_i;
        end
      end
      wwbc_pkg::ST_CHECK: begin
        hit_d = op_ok && in_win;
        wb_d  = 1'b0;
        rd_d  = '0;
        cnt_d = '0;
        if (op_ok && is_access && !in_win) begin
          wb_d = dirty_q;
          if (!dirty_q) begin
            base_d = new_base;
            held_d = 1'b1;
          end
        end else if (op_ok && is_flush && ((op_q == wwbc_pkg::OP_FLUSH) || in_win)) begin
          wb_d = dirty_q;
          if (!dirty_q) begin
            held_d = 1'b0;
            base_d = wwbc_pkg::BASE_NONE;
          end
        end
      end
      wwbc_pkg::ST_WB: begin
        if (!cnt_end) mem_ctrl.buf_raddr = cnt_q[BUF_AW-1:0];
        if ((cnt_q != '0) && inr_prev_q) begin
          mem_ctrl.ram_we    = 1'b1;
          mem_ctrl.ram_waddr = sum_prev_q;
          mem_ctrl.ram_wdata = buf_rdata;
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_end) begin
          cnt_d   = '0;
          dirty_d = 1'b0;
          if (is_flush) begin
            held_d = 1'b0;
            base_d = wwbc_pkg::BASE_NONE;
          end else begin
            held_d = 1'b1;
            base_d = new_base;
          end
        end
      end
      wwbc_pkg::ST_FILL: begin
        if (!cnt_end) begin
          mem_ctrl.ram_re    = inr;
          mem_ctrl.ram_raddr = sum;
        end
        if (cnt_q != '0) begin
          mem_ctrl.buf_we    = 1'b1;
          mem_ctrl.buf_waddr = BUF_AW'(cnt_q - CNT_W'(1));
          mem_ctrl.buf_wdata = inr_prev_q ? ram_rdata : 8'h00;
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_end) begin
          cnt_d   = '0;
          dirty_d = 1'b0;
        end
      end
      wwbc_pkg::ST_ACC_A: begin
        mem_ctrl.buf_raddr = off;
        if (!is_read) begin
          mem_ctrl.buf_we    = 1'b1;
          mem_ctrl.buf_waddr = off;
          mem_ctrl.buf_wdata = data_q[7:0];
          dirty_d            = 1'b1;
        end
      end
      wwbc_pkg::ST_ACC_B: begin
        mem_ctrl.buf_raddr = off1;
        if (is_read) begin
          rd_d[7:0] = buf_rdata;
        end else begin
          mem_ctrl.buf_we    = 1'b1;
          mem_ctrl.buf_waddr = off1;
          mem_ctrl.buf_wdata = data_q[15:8];
        end
      end
      wwbc_pkg::ST_ACC_C: begin
        if (is_word) rd_d[15:8] = buf_rdata;
        else         rd_d       = {8'h00, buf_rdata};
      end
      wwbc_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_rd_d    = rd_q;
          out_hit_d   = hit_q;
          out_wb_d    = wb_q;
          out_start_d = base_q;
          out_held_d  = held_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wwbc_pkg::ST_IDLE;
      base_q      <= wwbc_pkg::BASE_NONE;
      held_q      <= 1'b0;
      dirty_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      held_q      <= held_d;
      dirty_q     <= dirty_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    addr_q      <= addr_d;
    data_q      <= data_d;
    hit_q       <= hit_d;
    wb_q        <= wb_d;
    rd_q        <= rd_d;
    sum_prev_q  <= sum;
    inr_prev_q  <= inr;
    out_rd_q    <= out_rd_d;
    out_hit_q   <= out_hit_d;
    out_wb_q    <= out_wb_d;
    out_start_q <= out_start_d;
    out_held_q  <= out_held_d;
  end

  assign out_valid_o    = out_valid_q;
  assign read_data_o    = out_rd_q;
  assign hit_o          = out_hit_q;
  assign wrote_back_o   = out_wb_q;
  assign window_start_o = out_start_q;
  assign window_valid_o = out_held_q;

endmodule
